@@ design/prq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Package for the priority ready queue.
// Holds the queue size, field widths, opcodes and status codes.
// No dependencies.
package prq_pkg;

  localparam int unsigned MaxThreads = 16;
  localparam int unsigned IdxW       = $clog2(MaxThreads);
  localparam int unsigned CntW       = $clog2(MaxThreads + 1);
  localparam int unsigned ThreadW    = 4;
  localparam int unsigned PrioW      = 3;
  localparam int unsigned OpW        = 2;

  typedef logic [ThreadW-1:0]       thread_t;
  typedef logic signed [PrioW-1:0]  prio_t;
  typedef logic [OpW-1:0]           op_t;
  typedef logic [CntW-1:0]          cnt_t;

  localparam op_t OpInsert = 2'd0;
  localparam op_t OpRemove = 2'd1;
  localparam op_t OpChprio = 2'd2;

  typedef enum logic [1:0] {
    StsOk        = 2'd0,
    StsNotFound  = 2'd1,
    StsQueued    = 2'd2,
    StsFull      = 2'd3
  } status_e;

endpackage
`default_nettype wire

@@ design/priority_ready_queue_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Priority ready queue: top level with the slot array and its sequencer.
// Depends on prq_pkg.
//
// Usage:
// - The input channel carries one operation per item: insert, remove or
//   change priority of a thread; the unused opcode leaves the queue alone. Each
//   operation returns one output item: status, head thread and queued count.
// - The queue is a slot array kept in descending priority order. One slot is
//   read and one slot written per cycle while a small sequencer scans for the
//   thread, closes the gap left by a removal and opens a gap for an insertion.
// - The scan reads one slot per cycle up to the thread's slot, or one past the
//   last slot when the thread is absent. A removal then moves each slot behind
//   the thread up by one, and an insertion moves each slot of lower or equal
//   priority down by one and writes the new thread into the gap; the single
//   slot read port is why these steps go one slot at a time.
// - in_ready_o is high only while the sequencer is idle.
// - A finished result sits in an output register. A new item is accepted while
//   that result waits; a second result waits in the sequencer until the
//   receiver takes the first one.
// - Reset empties the queue and drops any pending result. Slot contents are
//   not cleared; only values of slots below the fill count are ever used.
module priority_ready_queue_top
  import prq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [OpW-1:0]    opcode_i,
  input  wire logic [ThreadW-1:0] thread_num_i,
  input  wire logic signed [PrioW-1:0] prio_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             status_o,
  output logic                   head_valid_o,
  output logic [ThreadW-1:0]     head_thread_o,
  output logic [CntW-1:0]        queued_count_o
);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StRemove,
    StInsert,
    StFinish
  } state_e;

  state_e  state_q, state_d;
  op_t     op_q, op_d;
  thread_t thr_q, thr_d;
  prio_t   prio_q, prio_d;
  cnt_t    idx_q, idx_d;
  cnt_t    occ_q, occ_d;
  status_e status_q, status_d;

  logic    out_valid_q, out_valid_d;
  status_e res_status_q, res_status_d;
  logic    res_head_valid_q, res_head_valid_d;
  thread_t res_head_q, res_head_d;
  cnt_t    res_count_q, res_count_d;

  thread_t slot_thread_q [MaxThreads];
  prio_t   slot_prio_q   [MaxThreads];

  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  thread_t         wr_thr;
  prio_t           wr_prio;
  logic [IdxW-1:0] rd_idx;
  thread_t         rd_thr;
  prio_t           rd_prio;
  cnt_t            idx_nxt;
  cnt_t            idx_prv;
  logic            scan_hit;
  logic            scan_end;

  assign idx_nxt = idx_q + cnt_t'(1);
  assign idx_prv = idx_q - cnt_t'(1);

  always_comb begin
    case (state_q)
      StRemove: rd_idx = idx_nxt[IdxW-1:0];
      StInsert: rd_idx = idx_prv[IdxW-1:0];
      default:  rd_idx = idx_q[IdxW-1:0];
    endcase
  end

  assign rd_thr   = slot_thread_q[rd_idx];
  assign rd_prio  = slot_prio_q[rd_idx];
  assign scan_end = (idx_q == occ_q);
  assign scan_hit = (idx_q < occ_q) && (rd_thr == thr_q);

  always_comb begin
    state_d          = state_q;
    op_d             = op_q;
    thr_d            = thr_q;
    prio_d           = prio_q;
    idx_d            = idx_q;
    occ_d            = occ_q;
    status_d         = status_q;
    out_valid_d      = out_valid_q;
    res_status_d     = res_status_q;
    res_head_valid_d = res_head_valid_q;
    res_head_d       = res_head_q;
    res_count_d      = res_count_q;
    wr_en            = 1'b0;
    wr_idx           = idx_q[IdxW-1:0];
    wr_thr           = rd_thr;
    wr_prio          = rd_prio;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d     = opcode_i;
          thr_d    = thread_num_i;
          prio_d   = prio_i;
          idx_d    = '0;
          status_d = StsOk;
          state_d  = StScan;
        end
      end
      StScan: begin
        if (scan_hit || scan_end) begin
          if (op_q == OpInsert) begin
            if (scan_hit) begin
              status_d = StsQueued;
              state_d  = StFinish;
            end else if (occ_q == cnt_t'(MaxThreads)) begin
              status_d = StsFull;
              state_d  = StFinish;
            end else begin
              idx_d   = occ_q;
              state_d = StInsert;
            end
          end else if (op_q == OpRemove || op_q == OpChprio) begin
            if (scan_hit) begin
              state_d = StRemove;
            end else begin
              status_d = StsNotFound;
              state_d  = StFinish;
            end
          end else begin
            state_d = StFinish;
          end
        end else begin
          idx_d = idx_nxt;
        end
      end
      StRemove: begin
        if (idx_nxt < occ_q) begin
          wr_en = 1'b1;
          idx_d = idx_nxt;
        end else begin
          occ_d = occ_q - cnt_t'(1);
          if (op_q == OpChprio) begin
            idx_d   = occ_q - cnt_t'(1);
            state_d = StInsert;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StInsert: begin
        wr_en = 1'b1;
        if ((idx_q != '0) && (rd_prio <= prio_q)) begin
          idx_d = idx_prv;
        end else begin
          wr_thr  = thr_q;
          wr_prio = prio_q;
          occ_d   = occ_q + cnt_t'(1);
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          res_status_d     = status_q;
          res_head_valid_d = (occ_q != '0);
          res_head_d       = (occ_q != '0) ? slot_thread_q[0] : '0;
          res_count_d      = occ_q;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      op_q             <= OpInsert;
      thr_q            <= '0;
      prio_q           <= '0;
      idx_q            <= '0;
      occ_q            <= '0;
      status_q         <= StsOk;
      out_valid_q      <= 1'b0;
      res_status_q     <= StsOk;
      res_head_valid_q <= 1'b0;
      res_head_q       <= '0;
      res_count_q      <= '0;
    end else begin
      state_q          <= state_d;
      op_q             <= op_d;
      thr_q            <= thr_d;
      prio_q           <= prio_d;
      idx_q            <= idx_d;
      occ_q            <= occ_d;
      status_q         <= status_d;
      out_valid_q      <= out_valid_d;
      res_status_q     <= res_status_d;
      res_head_valid_q <= res_head_valid_d;
      res_head_q       <= res_head_d;
      res_count_q      <= res_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_thread_q[wr_idx] <= wr_thr;
      slot_prio_q[wr_idx]   <= wr_prio;
    end
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign status_o       = res_status_q;
  assign head_valid_o   = res_head_valid_q;
  assign head_thread_o  = res_head_q;
  assign queued_count_o = res_count_q;

endmodule
`default_nettype wire

@@ design/prq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the priority ready queue, with its bind statement.
// Depends on prq_pkg and priority_ready_queue_top.
module prq_checker
  import prq_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic [OpW-1:0]           opcode_i,
  input wire logic [ThreadW-1:0]       thread_num_i,
  input wire logic signed [PrioW-1:0]  prio_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic [1:0]               status_o,
  input wire logic                     head_valid_o,
  input wire logic [ThreadW-1:0]       head_thread_o,
  input wire logic [CntW-1:0]          queued_count_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again while an item is in progress");

  a_head_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_valid_o == (queued_count_o != '0)))
    else $error("head valid disagrees with queued count");

  a_empty_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !head_valid_o) |-> (head_thread_o == '0))
    else $error("empty queue reports a nonzero head thread");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (queued_count_o <= CntW'(MaxThreads)))
    else $error("queued count exceeds queue size");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o)
      && $stable(queued_count_o)))
    else $error("stalled result item changed");

endmodule

bind priority_ready_queue_top prq_checker u_prq_checker (.*);
`default_nettype wire

@@ dv/priority_ready_queue_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for priority_ready_queue_top, the sorted thread ready queue.
// Uses prq_pkg for widths, opcodes and status codes, and needs nothing beyond the RTL.
module priority_ready_queue_top_tb;
  import prq_pkg::*;

  localparam op_t OpUnused = 2'd3;

  typedef struct packed {
    op_t     op;
    thread_t thread;
    prio_t   prio;
  } sched_op_t;

  typedef struct packed {
    status_e status;
    logic    head_valid;
    thread_t head_thread;
    cnt_t    count;
  } queue_view_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_ready_o;
  op_t          opcode_i = OpInsert;
  thread_t      thread_num_i = '0;
  prio_t        prio_i = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  logic [1:0]   status_o;
  logic         head_valid_o;
  thread_t      head_thread_o;
  cnt_t         queued_count_o;

  sched_op_t    pending_ops[$];
  queue_view_t  expected_views[$];
  thread_t      ready_thread[MaxThreads];
  prio_t        ready_prio[MaxThreads];
  int           ready_fill = 0;
  int           send_idle_pct = 33;
  int           recv_idle_pct = 63;
  int           fail_count = 0;
  logic         in_taken = 1'b0;

  priority_ready_queue_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .thread_num_i  (thread_num_i),
    .prio_i        (prio_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .head_valid_o  (head_valid_o),
    .head_thread_o (head_thread_o),
    .queued_count_o(queued_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void ready_put(thread_t t, prio_t p);
    int pos;
    pos = 0;
    while (pos < ready_fill && ready_prio[pos] > p) pos++;
    for (int i = ready_fill; i > pos; i--) begin
      ready_thread[i] = ready_thread[i-1];
      ready_prio[i]   = ready_prio[i-1];
    end
    ready_thread[pos] = t;
    ready_prio[pos]   = p;
    ready_fill++;
  endfunction

  function automatic queue_view_t schedule_op(sched_op_t item);
    queue_view_t view;
    int          pos;
    pos = -1;
    view.status = StsOk;
    for (int i = 0; i < ready_fill; i++) begin
      if (pos < 0 && ready_thread[i] == item.thread) pos = i;
    end
    case (item.op)
      OpInsert: begin
        if (pos >= 0) view.status = StsQueued;
        else if (ready_fill >= MaxThreads) view.status = StsFull;
        else ready_put(item.thread, item.prio);
      end
      OpRemove, OpChprio: begin
        if (pos < 0) begin
          view.status = StsNotFound;
        end else begin
          for (int i = pos; i + 1 < ready_fill; i++) begin
            ready_thread[i] = ready_thread[i+1];
            ready_prio[i]   = ready_prio[i+1];
          end
          ready_fill--;
          if (item.op == OpChprio) ready_put(item.thread, item.prio);
        end
      end
      default: ;
    endcase
    view.head_valid  = (ready_fill > 0);
    view.head_thread = (ready_fill > 0) ? ready_thread[0] : '0;
    view.count       = cnt_t'(ready_fill);
    return view;
  endfunction

  function automatic void note_failure(string msg);
    if (fail_count < 10) $display("%t: %s", $realtime, msg);
    fail_count++;
  endfunction

  always @(posedge clk_i) begin : monitor_blk
    queue_view_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_views.size() == 0) begin
          note_failure($sformatf("unexpected result status=%0d head=%0d/%0d count=%0d",
                                 status_o, head_valid_o, head_thread_o, queued_count_o));
        end else begin
          want = expected_views.pop_front();
          if (status_o !== want.status || head_valid_o !== want.head_valid ||
              head_thread_o !== want.head_thread || queued_count_o !== want.count) begin
            note_failure($sformatf(
              "mismatch: expected status=%0d head=%0d/%0d count=%0d, got %0d %0d/%0d %0d",
              want.status, want.head_valid, want.head_thread, want.count,
              status_o, head_valid_o, head_thread_o, queued_count_o));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_views.push_back(schedule_op('{opcode_i, thread_num_i, prio_i}));
      end
      in_taken <= in_valid_i && in_ready_o;
    end
  end

  always @(negedge clk_i) begin : driver_blk
    logic      next_valid;
    sched_op_t item;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && in_taken) next_valid = 1'b0;
      if (!next_valid && pending_ops.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        item = pending_ops.pop_front();
        opcode_i     <= item.op;
        thread_num_i <= item.thread;
        prio_i       <= item.prio;
        next_valid   = 1'b1;
      end
      in_valid_i  <= next_valid;
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_op(op_t op, int t, int p);
    pending_ops.push_back('{op, thread_t'(t), prio_t'(p)});
  endtask

  // Inserts come in runs of varying density so the queue drifts between empty and full.
  task automatic add_random_ops(int n);
    int  insert_pct;
    int  roll;
    op_t op;
    insert_pct = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 15;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 4) op = OpUnused;
      else if (roll < insert_pct) op = OpInsert;
      else op = $urandom_range(1) ? OpRemove : OpChprio;
      add_op(op, $urandom_range(15), $urandom_range(7));
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid_i || expected_views.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_op(OpRemove, 5, 0);
    add_op(OpChprio, 5, 1);
    add_op(OpUnused, 2, 0);
    add_op(OpInsert, 0, -4);
    add_op(OpInsert, 15, 3);
    add_op(OpInsert, 7, 0);
    add_op(OpInsert, 8, 0);
    add_op(OpInsert, 8, 1);
    add_op(OpInsert, 3, -4);
    add_op(OpChprio, 0, 3);
    add_op(OpChprio, 15, -1);
    add_op(OpRemove, 0, 0);
    add_op(OpRemove, 3, 0);
    add_op(OpRemove, 3, 0);
    add_op(OpUnused, 8, 2);
    add_op(OpInsert, 1, 2);
    add_op(OpChprio, 1, 2);
    add_op(OpRemove, 8, 0);
    add_op(OpRemove, 7, 0);
    add_op(OpRemove, 1, 0);
    add_op(OpRemove, 15, 0);
    add_random_ops(360);
    wait_drained();

    send_idle_pct = 63;
    recv_idle_pct = 33;
    add_random_ops(360);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_ops(360);
    wait_drained();

    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && expected_views.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
